// ----- rtl/core/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants for the signed q24.8 fixed-point alu
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int WordBits = 32;
    localparam int FracBits = 8;
    localparam int QuotBits = WordBits + FracBits;   // quotient width
    localparam int QueueDepth = 4;
    localparam int QueuePtrBits = 2;

    localparam logic [WordBits-1:0] MaxWord = {1'b0, {(WordBits-1){1'b1}}};
    localparam logic [WordBits-1:0] MinWord = {1'b1, {(WordBits-1){1'b0}}};

    typedef enum logic [3:0] {
        ACT_ADD  = 4'd0,  ACT_SUB  = 4'd1,  ACT_MUL  = 4'd2,  ACT_DIV  = 4'd3,
        ACT_GT   = 4'd4,  ACT_LT   = 4'd5,  ACT_GE   = 4'd6,  ACT_LE   = 4'd7,
        ACT_EQ   = 4'd8,  ACT_NE   = 4'd9,  ACT_MAX  = 4'd10, ACT_MIN  = 4'd11,
        ACT_INC  = 4'd12, ACT_DEC  = 4'd13, ACT_FINT = 4'd14, ACT_TINT = 4'd15
    } t_action;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_OVF  = 2'd1,
        ERR_DIV0 = 2'd2
    } t_err;

    // classified operation handed from front to back
    typedef struct packed {
        t_action               act;
        logic                  neg;      // sign of mul/div/conversion result
        logic [WordBits-1:0]   a;
        logic [WordBits-1:0]   b;
        logic [WordBits-1:0]   mag_a;
        logic [WordBits-1:0]   mag_b;
    } t_op;

    typedef struct packed {
        logic [WordBits-1:0] value;
        logic                cmp;
        t_err                err;
    } t_res;

endpackage

// ----- rtl/core/fpa_front.sv -----
// ----------------------------------------------------------------------------
// fpa_front
// decodes an incoming request into magnitudes and result sign
// ----------------------------------------------------------------------------
module fpa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  fpa_pkg::t_action              i_act,
    input  logic [fpa_pkg::WordBits-1:0]  i_a,
    input  logic [fpa_pkg::WordBits-1:0]  i_b,
    output logic                          o_valid,
    input  logic                          i_ready,
    output fpa_pkg::t_op                  o_op
);
    import fpa_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;

    // classification: magnitudes and sign of signed-magnitude results
    always_comb begin
        n_op.act   = i_act;
        n_op.a     = i_a;
        n_op.b     = i_b;
        n_op.mag_a = i_a[WordBits-1] ? (~i_a + 1'b1) : i_a;
        n_op.mag_b = i_b[WordBits-1] ? (~i_b + 1'b1) : i_b;
        if (i_act == ACT_MUL || i_act == ACT_DIV) begin
            n_op.neg = i_a[WordBits-1] ^ i_b[WordBits-1];
        end else begin
            n_op.neg = i_a[WordBits-1];
        end
    end

    assign o_ready = !r_valid || i_ready;

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_op <= n_op;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
endmodule

// ----- rtl/core/fpa_queue.sv -----
// ----------------------------------------------------------------------------
// fpa_queue
// short fifo decoupling the front from the execution pipe
// ----------------------------------------------------------------------------
module fpa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fpa_pkg::t_op  i_op,
    output logic          o_valid,
    input  logic          i_ready,
    output fpa_pkg::t_op  o_op
);
    import fpa_pkg::*;

    t_op                   r_mem [QueueDepth];
    logic [QueuePtrBits-1:0] r_wr;
    logic [QueuePtrBits-1:0] r_rd;
    logic [QueuePtrBits:0]   r_cnt;
    logic                    wr_en;
    logic                    rd_en;

    assign o_ready = (r_cnt != (QueuePtrBits+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = o_valid && i_ready;
    assign o_op    = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QueuePtrBits+1)'(wr_en) - (QueuePtrBits+1)'(rd_en);
        end
    end
endmodule

// ----- rtl/core/fpa_back.sv -----
// ----------------------------------------------------------------------------
// fpa_back
// execution pipe: pipelined multiplier, restoring divider, simple ops
// ----------------------------------------------------------------------------
module fpa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  fpa_pkg::t_op                  i_op,
    output logic                          o_valid,
    input  logic                          i_ready,
    output fpa_pkg::t_res                 o_res
);
    import fpa_pkg::*;

    // one stage per quotient bit, plus entry, product and pack stages
    localparam int Stages = QuotBits + 3;
    localparam int W = WordBits;

    typedef struct packed {
        logic              vld;
        t_action           act;
        logic              neg;
        t_res              simple;   // finished result for non mul/div ops
        logic [2*W-1:0]    prod;     // rounded product magnitude
        logic [QuotBits-1:0] num;    // dividend bits, shifted out msb first
        logic [QuotBits-1:0] quo;
        logic [W:0]        rem;
        logic [W-1:0]      den;
    } t_stage;

    t_stage r_st [Stages];
    t_stage n_st [Stages];
    t_stage n_first;
    t_res   r_out;
    logic   r_out_vld;
    logic   adv;

    assign adv     = !r_out_vld || i_ready;
    assign o_ready = adv;

    // simple ops evaluated at entry
    logic [W-1:0] sum, dif, inc, dec;
    logic         sgt, slt;
    always_comb begin
        sum = i_op.a + i_op.b;
        dif = i_op.a - i_op.b;
        inc = i_op.a + 1'b1;
        dec = i_op.a - 1'b1;
        sgt = $signed(i_op.a) > $signed(i_op.b);
        slt = $signed(i_op.a) < $signed(i_op.b);
        n_first        = '0;
        n_first.vld    = i_valid;
        n_first.act    = i_op.act;
        n_first.neg    = i_op.neg;
        n_first.den    = i_op.mag_b;
        n_first.num    = {i_op.mag_a, {FracBits{1'b0}}};
        n_first.simple = '0;
        case (i_op.act)
            ACT_ADD: begin
                if (i_op.a[W-1] == i_op.b[W-1] && sum[W-1] != i_op.a[W-1]) begin
                    n_first.simple.value = i_op.a[W-1] ? MinWord : MaxWord;
                    n_first.simple.err   = ERR_OVF;
                end else n_first.simple.value = sum;
            end
            ACT_SUB: begin
                if (i_op.a[W-1] != i_op.b[W-1] && dif[W-1] != i_op.a[W-1]) begin
                    n_first.simple.value = i_op.a[W-1] ? MinWord : MaxWord;
                    n_first.simple.err   = ERR_OVF;
                end else n_first.simple.value = dif;
            end
            ACT_GT: n_first.simple.cmp = sgt;
            ACT_LT: n_first.simple.cmp = slt;
            ACT_GE: n_first.simple.cmp = !slt;
            ACT_LE: n_first.simple.cmp = !sgt;
            ACT_EQ: n_first.simple.cmp = (i_op.a == i_op.b);
            ACT_NE: n_first.simple.cmp = (i_op.a != i_op.b);
            ACT_MAX: n_first.simple.value = sgt ? i_op.a : i_op.b;
            ACT_MIN: n_first.simple.value = slt ? i_op.a : i_op.b;
            ACT_INC: begin
                if (i_op.a == MaxWord) begin
                    n_first.simple.value = MaxWord;
                    n_first.simple.err   = ERR_OVF;
                end else n_first.simple.value = inc;
            end
            ACT_DEC: begin
                if (i_op.a == MinWord) begin
                    n_first.simple.value = MinWord;
                    n_first.simple.err   = ERR_OVF;
                end else n_first.simple.value = dec;
            end
            ACT_FINT: begin
                if (i_op.neg ? (i_op.mag_a > (MinWord >> FracBits))
                             : (i_op.mag_a > (MaxWord >> FracBits))) begin
                    n_first.simple.value = i_op.neg ? MinWord : MaxWord;
                    n_first.simple.err   = ERR_OVF;
                end else begin
                    n_first.simple.value = i_op.a << FracBits;
                end
            end
            ACT_TINT: begin
                n_first.simple.value = i_op.neg ? (~(i_op.mag_a >> FracBits) + 1'b1)
                                                : (i_op.mag_a >> FracBits);
            end
            default: ;
        endcase
    end

    // next contents of every pipe stage
    always_comb begin
        logic [W:0] trial;
        n_st[0] = n_first;
        // product stage
        n_st[1]      = r_st[0];
        n_st[1].prod = (r_st[0].num[QuotBits-1 -: W] * r_st[0].den)
                       + (2*W)'(1 << (FracBits-1));
        // one quotient bit per stage
        for (int s = 2; s < Stages - 1; s++) begin
            trial         = {r_st[s-1].rem[W-1:0], r_st[s-1].num[QuotBits-1]};
            n_st[s]       = r_st[s-1];
            n_st[s].num   = r_st[s-1].num << 1;
            if (trial >= {1'b0, r_st[s-1].den}) begin
                n_st[s].rem = trial - {1'b0, r_st[s-1].den};
                n_st[s].quo = {r_st[s-1].quo[QuotBits-2:0], 1'b1};
            end else begin
                n_st[s].rem = trial;
                n_st[s].quo = {r_st[s-1].quo[QuotBits-2:0], 1'b0};
            end
        end
        n_st[Stages-1] = r_st[Stages-2];
    end

    // pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Stages; i++) r_st[i].vld <= 1'b0;
        end else if (adv) begin
            for (int i = 0; i < Stages; i++) r_st[i] <= n_st[i];
        end
    end

    // final rounding, saturation and packing
    t_stage       last;
    t_res         n_res;
    logic [2*W-1:0] pm;
    logic [QuotBits:0] qm;
    logic [W:0]   lim;
    always_comb begin
        last  = r_st[Stages-1];
        n_res = last.simple;
        lim   = last.neg ? {1'b0, MinWord} : {1'b0, MaxWord};
        pm    = last.prod >> FracBits;
        qm    = {1'b0, last.quo} +
                (QuotBits+1)'(last.rem >= ({1'b0, last.den} - last.rem));
        if (last.act == ACT_MUL) begin
            if (pm > (2*W)'(lim)) begin
                n_res.value = last.neg ? MinWord : MaxWord;
                n_res.err   = ERR_OVF;
            end else begin
                n_res.value = last.neg ? (~pm[W-1:0] + 1'b1) : pm[W-1:0];
                n_res.err   = ERR_NONE;
            end
        end else if (last.act == ACT_DIV) begin
            if (last.den == '0) begin
                n_res.value = '0;
                n_res.err   = ERR_DIV0;
            end else if (qm > (QuotBits+1)'(lim)) begin
                n_res.value = last.neg ? MinWord : MaxWord;
                n_res.err   = ERR_OVF;
            end else begin
                n_res.value = last.neg ? (~qm[W-1:0] + 1'b1) : qm[W-1:0];
                n_res.err   = ERR_NONE;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= last.vld;
        end
        if (adv) r_out <= n_res;
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;
endmodule

// ----- rtl/core/fixed_point_alu_q24_8_core.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core
// signed q24.8 fixed-point alu with saturation and rounded mul/div
// ----------------------------------------------------------------------------
// channel   dir  fields (lsb first)
// s_axis    in   tdata: operand_a[31:0], operand_b[63:32]; tuser: action[3:0]
// m_axis    out  tdata: value[31:0]; tuser: compare_true[0], error[2:1]
//
// one request per cycle while the output is not stalled; a request passes the decode
// register, the queue, the entry, product, quotient-bit and last pipe stages and the output
// register; the divider, which retires one quotient bit per stage, makes up most of the pipe.
// the queue between decode and execution absorbs short stalls; a stalled
// output freezes the whole execution pipe. reset is synchronous, active low.
module fixed_point_alu_q24_8_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
    input  logic [3:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [2:0]  m_axis_tuser    // compare_true, error
);
    import fpa_pkg::*;

    logic f_vld, f_rdy, q_vld, q_rdy;
    t_op  f_op, q_op;
    t_res res;

    // decode front
    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_act   (t_action'(s_axis_tuser)),
        .i_a     (s_axis_tdata[31:0]),
        .i_b     (s_axis_tdata[63:32]),
        .o_valid (f_vld),
        .i_ready (f_rdy),
        .o_op    (f_op)
    );

    // decoupling queue
    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_vld),
        .o_ready (f_rdy),
        .i_op    (f_op),
        .o_valid (q_vld),
        .i_ready (q_rdy),
        .o_op    (q_op)
    );

    // execution back
    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_vld),
        .o_ready (q_rdy),
        .i_op    (q_op),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = res.value;
    assign m_axis_tuser = {res.err, res.cmp};
endmodule
